// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the lexer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CLLX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that forces a consequence in the next cycle.
`define CLLX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cllx_pkg.sv -----
// Types, constants and character classes of the C-like token lexer.
package cllx_pkg;

  localparam int unsigned MAX_LINE_LEN = 4096;
  localparam int unsigned MAX_LINES    = 65535;
  localparam int unsigned COL_CAP      = (MAX_LINE_LEN < 8191) ? MAX_LINE_LEN : 8191;
  localparam int unsigned LINE_CAP     = (MAX_LINES < 65535) ? MAX_LINES : 65535;

  // default depth of the result queue; must be at least 4
  localparam int unsigned RES_DEPTH_DEF = 8;

  typedef logic [3:0]  kind_t;
  typedef logic [15:0] line_t;
  typedef logic [12:0] col_t;
  typedef logic [7:0]  char_t;

  localparam kind_t K_WORD    = 4'd0;
  localparam kind_t K_INT     = 4'd1;
  localparam kind_t K_FLOAT   = 4'd2;
  localparam kind_t K_CHAR    = 4'd3;
  localparam kind_t K_STRING  = 4'd4;
  localparam kind_t K_SYMBOL  = 4'd5;
  localparam kind_t K_SPACE   = 4'd6;
  localparam kind_t K_COMMENT = 4'd7;
  localparam kind_t K_ERROR   = 4'd8;

  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_DOT    = 8'h2E;

  typedef struct packed {
    kind_t kind;
    line_t line;
    col_t  col;
    col_t  len;
    logic  last;
  } res_t;

  function automatic logic is_alpha(input char_t c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
  endfunction

  function automatic logic is_digit(input char_t c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input char_t c);
    return (c >= 8'h09 && c <= 8'h0D) || (c == 8'h20);
  endfunction

  function automatic logic is_eol(input char_t c);
    return (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_symbol(input char_t c);
    logic r;
    case (c)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h3C, 8'h3E, 8'h21,
      8'h26, 8'h7C, 8'h5E, 8'h7E, 8'h40, 8'h23, 8'h28, 8'h29, 8'h5B,
      8'h5D, 8'h7B, 8'h7D, 8'h3B, 8'h2C, 8'h2E, 8'h3A, 8'h3F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/c_like_token_lexer_core.sv -----
// Top level of the C-like token lexer: scanner state machine and result queue.
//
// Input channel (in_*): one source byte per transfer in in_tdata[7:0], or a
// line end when in_tuser is high (the byte is then ignored). Result channel
// (out_*): one token per transfer, kind in out_tuser, line/column/length in
// out_tdata; out_tlast marks the last token caused by one input transfer.
// Every input transfer is scanned in the cycle it is taken: the scanner state
// and the zero to three tokens it produces are written at that clock edge, so
// the tokens are offered from the registered result queue, never combinationally.
// Throughput is one input transfer per cycle while the output keeps up; the
// single-width result port drains one token per cycle, so items that make two
// or three tokens hold the input back once the queue of RES_DEPTH entries has
// fewer than three free slots. in_tready depends only on the queue fill.
// A stalled receiver fills the queue; input keeps flowing until fewer than
// three slots remain, and no token is lost. After an unmatched byte or an
// unterminated literal one error token is sent and the scanner halts: later
// input is taken and dropped until reset. Synchronous reset empties the queue
// and returns to line 1, column 1, between tokens.
module c_like_token_lexer_core
  import cllx_pkg::*;
#(
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tuser,   // [0] line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] line_number, [28:16] start_column,
                                  // [41:29] token_length, [47:42] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
  localparam col_t  COL_CAP_C  = col_t'(COL_CAP);
  localparam line_t LINE_CAP_C = line_t'(LINE_CAP);

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_INT, M_INT_DOT, M_FLOAT, M_STR, M_STR_ESC, M_CHR_OPEN,
    M_CHR_ESC, M_CHR_BODY, M_SLASH, M_COMMENT, M_SPACE, M_HALT
  } mode_t;

  mode_t mode_r, mode_nxt;
  col_t  tok_start_r, tok_start_nxt;
  col_t  col_r, col_nxt;
  col_t  len_r, len_nxt;
  col_t  dot_col_r, dot_col_nxt;
  line_t line_r, line_nxt;

  res_t             mem_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic       in_acc, out_acc;
  char_t      ch;
  col_t       col_inc, len_inc, len_int;
  logic [1:0] n_emit;
  kind_t      ek [3];
  col_t       ec [3];
  col_t       el [3];
  logic [PTR_W-1:0] wr_idx [3];
  res_t       head;

  assign ch      = in_tdata;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign col_inc = (col_r < COL_CAP_C) ? col_r + 13'd1 : col_r;
  assign len_inc = (len_r < COL_CAP_C) ? len_r + 13'd1 : len_r;
  // integer part of a pending "digits then dot"
  assign len_int = (len_r > 13'd1) ? len_r - 13'd1 : 13'd1;

  // Scanner: next state and up to three tokens for the current input
  always_comb begin
    logic do_start;
    logic do_ext;
    logic do_fail;
    mode_nxt      = mode_r;
    tok_start_nxt = tok_start_r;
    col_nxt       = col_r;
    len_nxt       = len_r;
    dot_col_nxt   = dot_col_r;
    line_nxt      = line_r;
    n_emit        = 2'd0;
    do_start      = 1'b0;
    do_ext        = 1'b0;
    do_fail       = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ek[k] = K_WORD;
      ec[k] = '0;
      el[k] = '0;
    end

    if (mode_r != M_HALT) begin
      if (in_tuser) begin
        case (mode_r)
          M_WORD, M_INT, M_FLOAT, M_SPACE, M_COMMENT: begin
            case (mode_r)
              M_WORD:  ek[0] = K_WORD;
              M_INT:   ek[0] = K_INT;
              M_FLOAT: ek[0] = K_FLOAT;
              M_SPACE: ek[0] = K_SPACE;
              default: ek[0] = K_COMMENT;
            endcase
            ec[0]  = tok_start_r;
            el[0]  = len_r;
            n_emit = 2'd1;
          end
          M_SLASH: begin
            ek[0] = K_SYMBOL; ec[0] = tok_start_r; el[0] = 13'd1; n_emit = 2'd1;
          end
          M_INT_DOT: begin
            ek[0] = K_INT;    ec[0] = tok_start_r; el[0] = len_int;
            ek[1] = K_SYMBOL; ec[1] = dot_col_r;   el[1] = 13'd1;
            n_emit = 2'd2;
          end
          M_STR, M_STR_ESC, M_CHR_OPEN, M_CHR_ESC, M_CHR_BODY: begin
            ek[0] = K_ERROR; ec[0] = tok_start_r; el[0] = 13'd1; n_emit = 2'd1;
            do_fail = 1'b1;
          end
          default: ;
        endcase
        if (do_fail) begin
          mode_nxt = M_HALT;
        end else begin
          mode_nxt      = M_IDLE;
          line_nxt      = (line_r < LINE_CAP_C) ? line_r + 16'd1 : line_r;
          col_nxt       = 13'd1;
          tok_start_nxt = 13'd1;
          len_nxt       = '0;
        end
      end else begin
        case (mode_r)
          M_IDLE: do_start = 1'b1;
          M_WORD: begin
            if (is_alpha(ch) || is_digit(ch)) do_ext = 1'b1;
            else begin
              ek[0] = K_WORD; ec[0] = tok_start_r; el[0] = len_r; n_emit = 2'd1;
              do_start = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(ch)) do_ext = 1'b1;
            else if (ch == CH_DOT) begin
              dot_col_nxt = col_r;
              do_ext      = 1'b1;
              mode_nxt    = M_INT_DOT;
            end else begin
              ek[0] = K_INT; ec[0] = tok_start_r; el[0] = len_r; n_emit = 2'd1;
              do_start = 1'b1;
            end
          end
          M_INT_DOT: begin
            if (is_digit(ch)) begin
              do_ext   = 1'b1;
              mode_nxt = M_FLOAT;
            end else begin
              ek[0] = K_INT;    ec[0] = tok_start_r; el[0] = len_int;
              ek[1] = K_SYMBOL; ec[1] = dot_col_r;   el[1] = 13'd1;
              n_emit   = 2'd2;
              do_start = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(ch)) do_ext = 1'b1;
            else begin
              ek[0] = K_FLOAT; ec[0] = tok_start_r; el[0] = len_r; n_emit = 2'd1;
              do_start = 1'b1;
            end
          end
          M_STR: begin
            do_ext = 1'b1;
            if (ch == CH_DQUOTE) begin
              ek[0] = K_STRING; ec[0] = tok_start_r; el[0] = len_inc; n_emit = 2'd1;
              mode_nxt = M_IDLE;
            end else if (ch == CH_BSLASH) begin
              mode_nxt = M_STR_ESC;
            end
          end
          M_STR_ESC: begin
            if (is_eol(ch)) do_fail = 1'b1;
            else begin
              do_ext   = 1'b1;
              mode_nxt = M_STR;
            end
          end
          M_CHR_OPEN: begin
            if (ch == CH_SQUOTE) do_fail = 1'b1;
            else begin
              do_ext   = 1'b1;
              mode_nxt = (ch == CH_BSLASH) ? M_CHR_ESC : M_CHR_BODY;
            end
          end
          M_CHR_ESC: begin
            if (is_eol(ch)) do_fail = 1'b1;
            else begin
              do_ext   = 1'b1;
              mode_nxt = M_CHR_BODY;
            end
          end
          M_CHR_BODY: begin
            if (ch == CH_SQUOTE) begin
              do_ext = 1'b1;
              ek[0] = K_CHAR; ec[0] = tok_start_r; el[0] = len_inc; n_emit = 2'd1;
              mode_nxt = M_IDLE;
            end else do_fail = 1'b1;
          end
          M_SLASH: begin
            if (ch == CH_SLASH) begin
              do_ext   = 1'b1;
              mode_nxt = M_COMMENT;
            end else begin
              ek[0] = K_SYMBOL; ec[0] = tok_start_r; el[0] = 13'd1; n_emit = 2'd1;
              do_start = 1'b1;
            end
          end
          M_COMMENT: begin
            if (is_eol(ch)) begin
              ek[0] = K_COMMENT; ec[0] = tok_start_r; el[0] = len_r; n_emit = 2'd1;
              do_start = 1'b1;
            end else do_ext = 1'b1;
          end
          M_SPACE: begin
            if (is_space(ch)) do_ext = 1'b1;
            else begin
              ek[0] = K_SPACE; ec[0] = tok_start_r; el[0] = len_r; n_emit = 2'd1;
              do_start = 1'b1;
            end
          end
          default: ;
        endcase

        // literal broken: error at its opening quote
        if (do_fail) begin
          ek[0] = K_ERROR; ec[0] = tok_start_r; el[0] = 13'd1; n_emit = 2'd1;
          mode_nxt = M_HALT;
        end

        if (do_ext) begin
          len_nxt = len_inc;
          col_nxt = col_inc;
        end

        // first byte of a new token; flushed tokens come before it
        if (do_start) begin
          tok_start_nxt = col_r;
          len_nxt       = 13'd1;
          col_nxt       = col_inc;
          if (is_alpha(ch))            mode_nxt = M_WORD;
          else if (is_digit(ch))       mode_nxt = M_INT;
          else if (ch == CH_DQUOTE)    mode_nxt = M_STR;
          else if (ch == CH_SQUOTE)    mode_nxt = M_CHR_OPEN;
          else if (ch == CH_SLASH)     mode_nxt = M_SLASH;
          else if (is_space(ch))       mode_nxt = M_SPACE;
          else if (is_symbol(ch)) begin
            mode_nxt       = M_IDLE;
            ek[n_emit]     = K_SYMBOL;
            ec[n_emit]     = col_r;
            el[n_emit]     = 13'd1;
            n_emit         = n_emit + 2'd1;
          end else begin
            mode_nxt       = M_HALT;
            len_nxt        = '0;
            col_nxt        = col_r;
            ek[n_emit]     = K_ERROR;
            ec[n_emit]     = col_r;
            el[n_emit]     = 13'd1;
            n_emit         = n_emit + 2'd1;
          end
        end
      end
    end
  end

  // Result queue: up to three writes per transfer, one read
  always_comb begin
    logic [PTR_W:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum       = {1'b0, wr_ptr_r} + (PTR_W + 1)'(k);
      wr_idx[k] = (sum >= (PTR_W + 1)'(RES_DEPTH)) ?
                  PTR_W'(sum - (PTR_W + 1)'(RES_DEPTH)) : PTR_W'(sum);
    end
  end

  always_comb begin
    logic [1:0]       n_push;
    logic [PTR_W:0]   wsum;
    n_push     = in_acc ? n_emit : 2'd0;
    wsum       = {1'b0, wr_ptr_r} + (PTR_W + 1)'(n_push);
    wr_ptr_nxt = (wsum >= (PTR_W + 1)'(RES_DEPTH)) ?
                 PTR_W'(wsum - (PTR_W + 1)'(RES_DEPTH)) : PTR_W'(wsum);
    rd_ptr_nxt = rd_ptr_r;
    if (out_acc) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n_emit) begin
          mem_r[wr_idx[k]].kind <= ek[k];
          mem_r[wr_idx[k]].line <= line_r;
          mem_r[wr_idx[k]].col  <= ec[k];
          mem_r[wr_idx[k]].len  <= el[k];
          mem_r[wr_idx[k]].last <= (2'(k + 1) == n_emit);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      tok_start_r <= 13'd1;
      col_r       <= 13'd1;
      len_r       <= '0;
      dot_col_r   <= '0;
      line_r      <= 16'd1;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (in_acc) begin
        mode_r      <= mode_nxt;
        tok_start_r <= tok_start_nxt;
        col_r       <= col_nxt;
        len_r       <= len_nxt;
        dot_col_r   <= dot_col_nxt;
        line_r      <= line_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // room for the worst case of three tokens
  assign in_tready  = (cnt_r <= CNT_W'(RES_DEPTH - 3));
  assign head       = mem_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tdata  = {6'b0, head.len, head.col, head.line};
  assign out_tlast  = head.last;

  `include "assert_macros.svh"

  `CLLX_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(RES_DEPTH), "result queue overflow")
  `CLLX_ASSERT_ALWAYS(a_col_range, col_r != '0 && col_r <= COL_CAP_C, "column out of range")
  `CLLX_ASSERT_ALWAYS(a_line_nonzero, line_r != '0, "line counter is zero")
  `CLLX_ASSERT_NEXT(a_halt_sticky, mode_r == M_HALT, mode_r == M_HALT, "left halt without reset")

endmodule
